// ===== hw/rtl/rcu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_pkg
// Shared types and constants of the radix converter unit.
// ----------------------------------------------------------------------------
package rcu_pkg;

    localparam int VALUE_BITS    = 32;  // internal value, wraps modulo 2^32
    localparam int SRC_BITS      = 31;  // source_number width
    localparam int SRC_DIGITS    = 10;  // decimal digits of a 31-bit number
    localparam int HEX_CHARS     = 8;   // characters in/out of the hex text
    localparam int RESULT_DIGITS = 19;  // digits kept in digit_result
    localparam int OCT_DIGITS    = 11;  // octal digits of a 32-bit value
    localparam int CNT_W         = 5;   // step counters, up to 31
    localparam int DIGIT_W       = 64;
    localparam int TEXT_W        = 64;
    localparam int HEX_LEN_W     = 4;

    localparam logic [7:0] ASCII_ZERO      = 8'd48;
    localparam logic [7:0] ASCII_NINE      = 8'd57;
    localparam logic [7:0] ASCII_UPPER_A   = 8'd65;
    localparam logic [7:0] ASCII_UPPER_F   = 8'd70;
    localparam logic [7:0] ASCII_ALPHA_OFS = 8'd55;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    // start request for a sub-unit
    typedef struct packed {
        logic   start;
        radix_t radix;
    } rcu_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rcu_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_parse
// Reduces the source field to a 32-bit value: bit-serial binary to bcd
// for binary/octal sources, then one digit per cycle accumulation; one
// character per cycle for hex text; a decimal source is taken as is.
// ----------------------------------------------------------------------------
module rcu_parse
    import rcu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rcu_ctrl_t             ctrl,
    input  wire logic [SRC_BITS-1:0]   source_number,
    input  wire logic [TEXT_W-1:0]     hex_chars,
    input  wire logic [HEX_LEN_W-1:0]  hex_length,
    output logic                       done,
    output logic [VALUE_BITS-1:0]      value
);

    localparam int BCD_W = 4 * SRC_DIGITS;

    typedef enum logic [3:0] {
        P_IDLE   = 4'b0001,
        P_DABBLE = 4'b0010,
        P_HORNER = 4'b0100,
        P_HEX    = 4'b1000
    } parse_state_t;

    parse_state_t            state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    radix_t                  radix_reg, radix_next;
    logic [SRC_BITS-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [TEXT_W-1:0]       hex_reg, hex_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;

    logic [BCD_W-1:0]        bcd_adj;
    logic [7:0]              chr;
    logic                    chr_digit;
    logic                    chr_alpha;
    logic [3:0]              chr_nib;
    logic [HEX_LEN_W-1:0]    len_clip;

    // add-3 correction of every bcd digit before the shift
    always_comb
    begin
        for (int i = 0; i < SRC_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    assign chr       = hex_reg[TEXT_W-1 -: 8];
    assign chr_digit = (chr >= ASCII_ZERO) && (chr <= ASCII_NINE);
    assign chr_alpha = (chr >= ASCII_UPPER_A) && (chr <= ASCII_UPPER_F);
    assign chr_nib   = chr_digit ? 4'(chr - ASCII_ZERO) : 4'(chr - ASCII_ALPHA_OFS);
    assign len_clip  = (hex_length > HEX_LEN_W'(HEX_CHARS)) ?
                       HEX_LEN_W'(HEX_CHARS) : hex_length;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        radix_next = radix_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        hex_next   = hex_reg;
        acc_next   = acc_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (ctrl.start)
                begin
                    radix_next = ctrl.radix;
                    acc_next   = '0;
                    case (ctrl.radix)
                        RADIX_DEC:
                        begin
                            acc_next  = VALUE_BITS'(source_number);
                            done_next = 1'b1;
                        end
                        RADIX_HEX:
                        begin
                            hex_next   = hex_chars;
                            cnt_next   = CNT_W'(len_clip);
                            state_next = P_HEX;
                        end
                        default:
                        begin
                            bin_next   = source_number;
                            bcd_next   = '0;
                            cnt_next   = CNT_W'(SRC_BITS);
                            state_next = P_DABBLE;
                        end
                    endcase
                end
            end
            P_DABBLE:
            begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[SRC_BITS-1]};
                bin_next = {bin_reg[SRC_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    cnt_next   = CNT_W'(SRC_DIGITS);
                    state_next = P_HORNER;
                end
            end
            P_HORNER:
            begin
                // most significant digit first, weight by radix
                acc_next = ((radix_reg == RADIX_BIN) ?
                            {acc_reg[VALUE_BITS-2:0], 1'b0} :
                            {acc_reg[VALUE_BITS-4:0], 3'b000})
                           + VALUE_BITS'(bcd_reg[BCD_W-1 -: 4]);
                bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = P_IDLE;
                end
            end
            P_HEX:
            begin
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    // characters outside 0-9 / A-F are skipped
                    if (chr_digit || chr_alpha)
                    begin
                        acc_next = {acc_reg[VALUE_BITS-5:0], chr_nib};
                    end
                    hex_next = {hex_reg[TEXT_W-9:0], 8'h00};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        hex_reg   <= hex_next;
        acc_reg   <= acc_next;
    end

    assign done  = done_reg;
    assign value = acc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/rcu_emit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rcu_emit
// Writes a 32-bit value in the target radix: binary/octal digits one per
// cycle into a decimal accumulator, hex text one nibble per cycle; decimal as is.
// ----------------------------------------------------------------------------
module rcu_emit
    import rcu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rcu_ctrl_t             ctrl,
    input  wire logic [VALUE_BITS-1:0] value,
    output logic                       done,
    output logic [DIGIT_W-1:0]         digit_result,
    output logic [TEXT_W-1:0]          hex_text,
    output logic [HEX_LEN_W-1:0]       hex_text_length,
    output logic                       overflow
);

    localparam int W_BITS = VALUE_BITS + 1;  // holds 11 whole octal digits

    typedef enum logic [2:0] {
        E_IDLE   = 3'b001,
        E_DIGITS = 3'b010,
        E_HEX    = 3'b100
    } emit_state_t;

    emit_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    done_reg, done_next;
    radix_t                  radix_reg, radix_next;
    logic [W_BITS-1:0]       w_reg, w_next;
    logic [DIGIT_W-1:0]      digit_reg, digit_next;
    logic [TEXT_W-1:0]       text_reg, text_next;
    logic [HEX_LEN_W-1:0]    pos_reg, pos_next;
    logic                    overflow_reg, overflow_next;

    logic [3:0]              dgt;
    logic [3:0]              nib;
    logic [7:0]              nib_ascii;

    assign dgt       = (radix_reg == RADIX_BIN) ? {3'b000, w_reg[W_BITS-1]} :
                                                  {1'b0, w_reg[W_BITS-1 -: 3]};
    assign nib       = w_reg[W_BITS-1 -: 4];
    assign nib_ascii = (nib <= 4'd9) ? (8'(nib) + ASCII_ZERO) :
                                       (8'(nib) + ASCII_ALPHA_OFS);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        done_next     = 1'b0;
        radix_next    = radix_reg;
        w_next        = w_reg;
        digit_next    = digit_reg;
        text_next     = text_reg;
        pos_next      = pos_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            E_IDLE:
            begin
                if (ctrl.start)
                begin
                    radix_next    = ctrl.radix;
                    digit_next    = '0;
                    text_next     = '0;
                    pos_next      = '0;
                    overflow_next = 1'b0;
                    case (ctrl.radix)
                        RADIX_DEC:
                        begin
                            digit_next = DIGIT_W'(value);
                            done_next  = 1'b1;
                        end
                        RADIX_BIN:
                        begin
                            // only the low digits fit, the rest flags overflow
                            w_next = {value[RESULT_DIGITS-1:0],
                                      {(W_BITS-RESULT_DIGITS){1'b0}}};
                            overflow_next = |value[VALUE_BITS-1:RESULT_DIGITS];
                            cnt_next      = CNT_W'(RESULT_DIGITS);
                            state_next    = E_DIGITS;
                        end
                        RADIX_OCT:
                        begin
                            w_next     = {1'b0, value};
                            cnt_next   = CNT_W'(OCT_DIGITS);
                            state_next = E_DIGITS;
                        end
                        default:
                        begin
                            w_next     = {value, 1'b0};
                            cnt_next   = CNT_W'(HEX_CHARS);
                            state_next = E_HEX;
                        end
                    endcase
                end
            end
            E_DIGITS:
            begin
                // times ten plus the next digit
                digit_next = {digit_reg[DIGIT_W-4:0], 3'b000}
                           + {digit_reg[DIGIT_W-2:0], 1'b0}
                           + DIGIT_W'(dgt);
                w_next     = (radix_reg == RADIX_BIN) ?
                             {w_reg[W_BITS-2:0], 1'b0} :
                             {w_reg[W_BITS-4:0], 3'b000};
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            E_HEX:
            begin
                // leading zero nibbles are dropped
                if ((nib != 4'd0) || (pos_reg != '0))
                begin
                    text_next[TEXT_W-1 - 8*pos_reg[2:0] -: 8] = nib_ascii;
                    pos_next = pos_reg + HEX_LEN_W'(1);
                end
                w_next   = {w_reg[W_BITS-5:0], 4'b0000};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= E_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg    <= radix_next;
        w_reg        <= w_next;
        digit_reg    <= digit_next;
        text_reg     <= text_next;
        pos_reg      <= pos_next;
        overflow_reg <= overflow_next;
    end

    assign done            = done_reg;
    assign digit_result    = digit_reg;
    assign hex_text        = text_reg;
    assign hex_text_length = pos_reg;
    assign overflow        = overflow_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (pos_reg <= HEX_LEN_W'(HEX_CHARS)))
        else $error("hex length beyond character count");
    a_ovf_bin_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (radix_reg != RADIX_BIN)) |-> !overflow_reg)
        else $error("overflow outside binary target");
    a_text_hex_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (radix_reg != RADIX_HEX)) |-> (pos_reg == '0))
        else $error("hex text written for digit target");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/radix_converter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// radix_converter_unit
// Converts one number per word between binary, octal, decimal and hex.
// ----------------------------------------------------------------------------
// usage
//   input channel item_*: op (source radix in bits 3:2, target in 1:0),
//   source_number in digit-as-decimal form, or hex_chars/hex_length text
//   output channel result_*: digit_result, hex_text, hex_text_length,
//   overflow; one result word per input word, in order
//   one word is worked on at a time; item_stall is high from acceptance
//   until its result has moved into the output register
//   steps from acceptance to result_valid:
//     parse: binary/octal source by bit-serial bcd shifts, then digit
//     steps; hex source by one step per character (length capped at 8);
//     decimal source taken as is; emit: binary target 19 digits, octal 11,
//     hex 8 nibbles, decimal as is; parse done starts the emit unit, and
//     emit done loads the output register once that register is free
//   the next word can be accepted in the cycle after the result loads
//   the output register frees the converter: a finished result waits there
//   while the next word is accepted; if a result is done while the register
//   is still stalled, the converter holds it until the register drains
//   reset clears the control state; no word is pending after reset
// ----------------------------------------------------------------------------
module radix_converter_unit
    import rcu_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire logic [3:0]            op,
    input  wire logic [SRC_BITS-1:0]   source_number,
    input  wire logic [TEXT_W-1:0]     hex_chars,
    input  wire logic [HEX_LEN_W-1:0]  hex_length,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [DIGIT_W-1:0]         digit_result,
    output logic [TEXT_W-1:0]          hex_text,
    output logic [HEX_LEN_W-1:0]       hex_text_length,
    output logic                       overflow
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PARSE = 4'b0010,
        S_EMIT  = 4'b0100,
        S_WAIT  = 4'b1000
    } top_state_t;

    top_state_t              state_reg, state_next;
    logic                    result_valid_reg, result_valid_next;
    radix_t                  target_reg;
    logic [DIGIT_W-1:0]      digit_result_reg;
    logic [TEXT_W-1:0]       hex_text_reg;
    logic [HEX_LEN_W-1:0]    hex_text_length_reg;
    logic                    overflow_reg;

    rcu_ctrl_t               parse_ctrl;
    rcu_ctrl_t               emit_ctrl;
    logic                    parse_done;
    logic                    emit_done;
    logic [VALUE_BITS-1:0]   value;
    logic [DIGIT_W-1:0]      emit_digit;
    logic [TEXT_W-1:0]       emit_text;
    logic [HEX_LEN_W-1:0]    emit_len;
    logic                    emit_overflow;

    logic                    accept;
    logic                    out_free;
    logic                    load;

    // word accepted only while nothing is in flight
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // output register can take a new result this cycle
    assign out_free = !result_valid_reg || !result_stall;
    assign load     = (((state_reg == S_EMIT) && emit_done) || (state_reg == S_WAIT))
                      && out_free;

    assign parse_ctrl.start = accept;
    assign parse_ctrl.radix = radix_t'(op[3:2]);
    assign emit_ctrl.start  = parse_done;
    assign emit_ctrl.radix  = target_reg;

    rcu_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (parse_ctrl),
        .source_number (source_number),
        .hex_chars     (hex_chars),
        .hex_length    (hex_length),
        .done          (parse_done),
        .value         (value)
    );

    rcu_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (emit_ctrl),
        .value           (value),
        .done            (emit_done),
        .digit_result    (emit_digit),
        .hex_text        (emit_text),
        .hex_text_length (emit_len),
        .overflow        (emit_overflow)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_PARSE;
                end
            end
            S_PARSE:
            begin
                if (parse_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_done)
                begin
                    // emit unit holds its result while the register is full
                    state_next = out_free ? S_IDLE : S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            target_reg <= radix_t'(op[1:0]);
        end
        if (load)
        begin
            digit_result_reg    <= emit_digit;
            hex_text_reg        <= emit_text;
            hex_text_length_reg <= emit_len;
            overflow_reg        <= emit_overflow;
        end
    end

    assign result_valid    = result_valid_reg;
    assign digit_result    = digit_result_reg;
    assign hex_text        = hex_text_reg;
    assign hex_text_length = hex_text_length_reg;
    assign overflow        = overflow_reg;

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PARSE))
        else $error("accepted word did not start parsing");
    a_parse_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        parse_done |-> (state_reg == S_PARSE))
        else $error("parse finished outside parse phase");
    a_emit_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        emit_done |-> (state_reg == S_EMIT))
        else $error("emit finished outside emit phase");
    a_wait_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> (result_valid_reg && (result_stall || load)))
        else $error("result held back with output register free");
`endif

endmodule
`default_nettype wire
